>>> hw/rtl/csd_pkg.sv
// csd_pkg: shared types, constants and helper functions of the concentric square-to-disk unit
// depends on nothing; used by every other file of the block
package csd_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_ITERS = 30;
  localparam int R_W          = COORD_BITS + 1;   // radius, up to 2^B
  localparam int REM_W        = COORD_BITS + 2;   // divider remainder, below 2*radius
  localparam int Q_W          = COORD_BITS + 1;   // ratio quotient, up to 2^B
  localparam int AB_W         = COORD_BITS + 2;   // signed a, b
  localparam int X_W          = 34;               // cordic x/y in q30
  localparam int Z_W          = 33;               // residual angle in q30
  localparam int SH_W         = 5;                // cordic shift amount
  localparam int PROD_W       = Q_W + 30;

  localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314856;
  localparam logic [29:0] KINV_Q30       = 30'd652032874;

  typedef enum logic [1:0] {
    WEDGE_E,
    WEDGE_N,
    WEDGE_W,
    WEDGE_S
  } wedge_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    wedge_t           wedge;
    logic             thneg;
    logic             zero;
    logic [R_W-1:0]   r;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_beat_t;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    wedge_t                  wedge;
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   y;
    logic signed [Z_W-1:0]   z;
  } cor_beat_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 33'sd843314856;
      1:  v = 33'sd497837829;
      2:  v = 33'sd263043836;
      3:  v = 33'sd133525158;
      4:  v = 33'sd67021686;
      5:  v = 33'sd33543515;
      6:  v = 33'sd16775850;
      7:  v = 33'sd8388437;
      8:  v = 33'sd4194282;
      9:  v = 33'sd2097149;
      10: v = 33'sd1048575;
      11: v = 33'sd524287;
      12: v = 33'sd262143;
      13: v = 33'sd131071;
      14: v = 33'sd65535;
      15: v = 33'sd32767;
      16: v = 33'sd16383;
      17: v = 33'sd8191;
      18: v = 33'sd4095;
      19: v = 33'sd2047;
      20: v = 33'sd1023;
      21: v = 33'sd511;
      22: v = 33'sd255;
      23: v = 33'sd127;
      24: v = 33'sd63;
      25: v = 33'sd31;
      26: v = 33'sd15;
      27: v = 33'sd8;
      28: v = 33'sd4;
      29: v = 33'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // q30 coordinate in [-1,1] back to unsigned q0.B in [0,1], clamped
  function automatic logic [COORD_BITS-1:0] to_unit(input logic signed [X_W-1:0] v);
    logic signed [X_W:0] s;
    logic signed [X_W:0] o;
    logic [COORD_BITS-1:0] res;
    s = $signed({v[X_W-1], v}) + $signed((X_W+1)'(64'd1 << 30))
        + $signed((X_W+1)'(64'd1 << (30 - COORD_BITS)));
    o = s >>> (31 - COORD_BITS);
    if (s < 0) begin
      res = '0;
    end else if (o > $signed((X_W+1)'((64'd1 << COORD_BITS) - 1))) begin
      res = '1;
    end else begin
      res = o[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/csd_if.sv
// csd_in_if, csd_out_if: valid/ready channels of the concentric square-to-disk unit
// depends on csd_pkg for the coordinate width
interface csd_in_if import csd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] samp_x;
  logic [COORD_BITS-1:0] samp_y;
  logic                  last_in;
  modport source  (output valid, output samp_x, output samp_y, output last_in, input ready);
  modport sink    (input valid, input samp_x, input samp_y, input last_in, output ready);
  modport monitor (input valid, input samp_x, input samp_y, input last_in, input ready);
endinterface

interface csd_out_if import csd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] disk_x;
  logic [COORD_BITS-1:0] disk_y;
  logic                  last_out;
  modport source  (output valid, output disk_x, output disk_y, output last_out, input ready);
  modport sink    (input valid, input disk_x, input disk_y, input last_out, output ready);
  modport monitor (input valid, input disk_x, input disk_y, input last_out, input ready);
endinterface

>>> hw/rtl/csd_div_cell.sv
// csd_div_cell: one restoring-division cell, one quotient bit per cell
// depends on csd_pkg (div_beat_t)
module csd_div_cell import csd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  div_beat_t d_i,
  output div_beat_t d_o
);

  div_beat_t        beat_r;
  div_beat_t        beat_nxt;
  logic [REM_W-1:0] den;
  logic [REM_W-1:0] rest;
  logic             ge;

  always_comb begin
    den      = REM_W'(d_i.r);
    ge       = d_i.rem >= den;
    rest     = ge ? (d_i.rem - den) : d_i.rem;
    beat_nxt = d_i;
    beat_nxt.rem = {rest[REM_W-2:0], 1'b0};
    beat_nxt.q   = {d_i.q[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign d_o = beat_r;

endmodule

>>> hw/rtl/csd_cordic_cell.sv
// csd_cordic_cell: one cordic rotation micro-step with floor shifts
// depends on csd_pkg (cor_beat_t)
module csd_cordic_cell import csd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [SH_W-1:0]       shift,
  input  logic signed [Z_W-1:0] angle,
  input  cor_beat_t             c_i,
  output cor_beat_t             c_o
);

  cor_beat_t             beat_r;
  cor_beat_t             beat_nxt;
  logic signed [X_W-1:0] dx;
  logic signed [X_W-1:0] dy;

  always_comb begin
    dx       = c_i.y >>> shift;
    dy       = c_i.x >>> shift;
    beat_nxt = c_i;
    if (!c_i.z[Z_W-1]) begin
      beat_nxt.x = c_i.x - dx;
      beat_nxt.y = c_i.y + dy;
      beat_nxt.z = c_i.z - angle;
    end else begin
      beat_nxt.x = c_i.x + dx;
      beat_nxt.y = c_i.y - dy;
      beat_nxt.z = c_i.z + angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign c_o = beat_r;

endmodule

>>> hw/rtl/concentric_square_to_disk_unit.sv
// concentric_square_to_disk_unit: top level, wedge select, divider and cordic cell rows
// depends on csd_pkg, csd_if, csd_div_cell, csd_cordic_cell
//
// usage:
//   in_ch carries one unit-square sample per beat (samp_x, samp_y, last_in),
//   out_ch carries one disk sample per beat (disk_x, disk_y, last_out).
//   every input beat yields exactly one output beat, in order.
// pipeline: 17 divider cells + 1 multiply stage + 30 cordic cells + 1 output register = 49 register stages.
// throughput: one sample per cycle while in_ch.ready is high; the whole row of cells advances together.
// stall: when out_ch is held, the row keeps moving until one more result sits
//   in the skid register; then in_ch.ready drops until the receiver takes a beat.
// reset: rst_n (synchronous, active low) clears all valid bits; no results are
//   pending afterwards and in_ch.ready is high.
// the centre sample gives 2^(B-1) on both outputs.
module concentric_square_to_disk_unit import csd_pkg::*; (
  input logic clk,
  input logic rst_n,
  csd_in_if.sink    in_ch,
  csd_out_if.source out_ch
);

  localparam logic signed [AB_W-1:0] FULL = AB_W'(64'd1 << COORD_BITS);

  logic                   en;
  logic signed [AB_W-1:0] a;
  logic signed [AB_W-1:0] b;
  logic signed [AB_W-1:0] na;
  logic signed [AB_W-1:0] nb;
  logic [R_W-1:0]         abs_a;
  logic [R_W-1:0]         abs_b;
  logic [R_W-1:0]         num;
  div_beat_t              front;
  div_beat_t              div_c [Q_W+1];
  cor_beat_t              cor_c [CORDIC_ITERS+1];
  cor_beat_t              mul_r;
  cor_beat_t              mul_nxt;
  logic [PROD_W-1:0]      mag_full;
  logic [PROD_W-1:0]      kx_full;
  logic signed [Z_W-1:0]  mag;
  logic signed [X_W-1:0]  px;
  logic signed [X_W-1:0]  py;
  logic [COORD_BITS-1:0]  res_x;
  logic [COORD_BITS-1:0]  res_y;

  logic                   out_v_r;
  logic [COORD_BITS-1:0]  out_x_r;
  logic [COORD_BITS-1:0]  out_y_r;
  logic                   out_l_r;
  logic                   skid_v_r;
  logic [COORD_BITS-1:0]  skid_x_r;
  logic [COORD_BITS-1:0]  skid_y_r;
  logic                   skid_l_r;
  logic                   tail_v;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // map to [-1,1] and pick the wedge
  always_comb begin
    a     = $signed({1'b0, in_ch.samp_x, 1'b0}) - FULL;
    b     = $signed({1'b0, in_ch.samp_y, 1'b0}) - FULL;
    na    = -a;
    nb    = -b;
    abs_a = a[AB_W-1] ? na[R_W-1:0] : a[R_W-1:0];
    abs_b = b[AB_W-1] ? nb[R_W-1:0] : b[R_W-1:0];
    front       = '0;
    front.valid = in_ch.valid;
    front.last  = in_ch.last_in;
    if (a > nb) begin
      if (a > b) begin
        front.wedge = WEDGE_E;
        front.r     = a[R_W-1:0];
        front.thneg = b[AB_W-1];
        num         = abs_b;
      end else begin
        front.wedge = WEDGE_N;
        front.r     = b[R_W-1:0];
        front.thneg = (a > 0);
        num         = abs_a;
      end
    end else begin
      if (a < b) begin
        front.wedge = WEDGE_W;
        front.r     = na[R_W-1:0];
        front.thneg = !b[AB_W-1];
        num         = abs_b;
      end else begin
        front.wedge = WEDGE_S;
        front.r     = nb[R_W-1:0];
        front.thneg = a[AB_W-1];
        num         = abs_a;
      end
    end
    front.zero = (front.r == '0);
    front.rem  = REM_W'(num);
  end

  assign div_c[0] = front;

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    csd_div_cell u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (div_c[g]),
      .d_o   (div_c[g+1])
    );
  end

  // ratio to angle, radius times cordic gain correction
  always_comb begin
    mag_full = PROD_W'(div_c[Q_W].q) * PROD_W'(PI_QUARTER_Q30)
             + PROD_W'(64'd1 << (COORD_BITS - 1));
    kx_full  = PROD_W'(div_c[Q_W].r) * PROD_W'(KINV_Q30);
    mag      = Z_W'(mag_full >> COORD_BITS);
    mul_nxt       = '0;
    mul_nxt.valid = div_c[Q_W].valid;
    mul_nxt.last  = div_c[Q_W].last;
    mul_nxt.wedge = div_c[Q_W].wedge;
    mul_nxt.x     = X_W'(kx_full >> COORD_BITS);
    mul_nxt.y     = '0;
    if (div_c[Q_W].zero) begin
      mul_nxt.z = '0;
    end else if (div_c[Q_W].thneg) begin
      mul_nxt.z = -mag;
    end else begin
      mul_nxt.z = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.valid <= 1'b0;
    end else if (en) begin
      mul_r <= mul_nxt;
    end
  end

  assign cor_c[0] = mul_r;

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cor
    csd_cordic_cell u_cor (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .shift (SH_W'(g)),
      .angle (atan_q30(g)),
      .c_i   (cor_c[g]),
      .c_o   (cor_c[g+1])
    );
  end

  // quarter-turn by swap and negate
  always_comb begin
    case (cor_c[CORDIC_ITERS].wedge)
      WEDGE_E: begin
        px = cor_c[CORDIC_ITERS].x;
        py = cor_c[CORDIC_ITERS].y;
      end
      WEDGE_N: begin
        px = -cor_c[CORDIC_ITERS].y;
        py = cor_c[CORDIC_ITERS].x;
      end
      WEDGE_W: begin
        px = -cor_c[CORDIC_ITERS].x;
        py = -cor_c[CORDIC_ITERS].y;
      end
      default: begin
        px = cor_c[CORDIC_ITERS].y;
        py = -cor_c[CORDIC_ITERS].x;
      end
    endcase
    res_x  = to_unit(px);
    res_y  = to_unit(py);
    tail_v = en && cor_c[CORDIC_ITERS].valid;
  end

  // output register plus one skid beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && out_ch.ready) begin
      if (skid_v_r) begin
        out_x_r  <= skid_x_r;
        out_y_r  <= skid_y_r;
        out_l_r  <= skid_l_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= tail_v;
        out_x_r <= res_x;
        out_y_r <= res_y;
        out_l_r <= cor_c[CORDIC_ITERS].last;
      end
    end else if (out_v_r) begin
      if (tail_v) begin
        skid_v_r <= 1'b1;
        skid_x_r <= res_x;
        skid_y_r <= res_y;
        skid_l_r <= cor_c[CORDIC_ITERS].last;
      end
    end else begin
      out_v_r <= tail_v;
      out_x_r <= res_x;
      out_y_r <= res_y;
      out_l_r <= cor_c[CORDIC_ITERS].last;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.disk_x   = out_x_r;
  assign out_ch.disk_y   = out_y_r;
  assign out_ch.last_out = out_l_r;

endmodule
